// File: hw/rtl/hdf_pkg.sv
// ============================================================================
// hdf_pkg - shared types, constants and control store for the hex dump block
// Holds the control-word layout, the step program, the register map and the
// character helpers used by the sequencer, the datapath and the registers.
// ============================================================================
package hdf_pkg;

   // ---- register map (index = paddr[4:2]) ----
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_ROW_WIDTH     = 3'd0;
   localparam logic [2:0] REG_GROUP_SIZE    = 3'd1;
   localparam logic [2:0] REG_UPPERCASE     = 3'd2;
   localparam logic [2:0] REG_PLAIN_MODE    = 3'd3;
   localparam logic [2:0] REG_START_OFFSET  = 3'd4;
   localparam logic [2:0] REG_LENGTH_LIMIT  = 3'd5;
   localparam logic [2:0] REG_LIMIT_ENABLED = 3'd6;

   localparam logic [4:0] ROW_WIDTH_RESET  = 5'd16;
   localparam logic [4:0] GROUP_SIZE_RESET = 5'd2;

   // ---- characters ----
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TILDE   = 8'h7e;
   localparam logic [7:0] CH_DOT     = 8'h2e;
   localparam logic [7:0] CH_COLON   = 8'h3a;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_UPPER_A_M10 = 8'h37;  // 'A' less ten
   localparam logic [7:0] CH_LOWER_A_M10 = 8'h57;  // 'a' less ten

   localparam int ADDR_DIGITS    = 8;
   localparam int COLS_LIMIT     = 16;   // widest row any build supports

   // ---- control word ----
   typedef logic [3:0] step_type;

   localparam step_type STEP_WAIT    = 4'd0;
   localparam step_type STEP_ADDR    = 4'd1;
   localparam step_type STEP_COLON   = 4'd2;
   localparam step_type STEP_SEP     = 4'd3;
   localparam step_type STEP_GAP     = 4'd4;
   localparam step_type STEP_HEX_HI  = 4'd5;
   localparam step_type STEP_HEX_LO  = 4'd6;
   localparam step_type STEP_TRAIL   = 4'd7;
   localparam step_type STEP_PAD     = 4'd8;
   localparam step_type STEP_SIDE    = 4'd9;
   localparam step_type STEP_NEWLINE = 4'd10;

   typedef enum logic [2:0] {
      EMIT_NONE, EMIT_ADDR, EMIT_COLON, EMIT_SPACE,
      EMIT_HEX_HI, EMIT_HEX_LO, EMIT_SIDE, EMIT_NEWLINE
   } emit_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_COND, JMP_START, JMP_TAIL
   } jump_type;

   typedef enum logic [1:0] {
      COND_ALWAYS, COND_CNT_NZ, COND_SIDE_MORE, COND_MID_ROW
   } cond_type;

   typedef enum logic [1:0] {
      CNT_HOLD, CNT_LOAD_ADDR, CNT_LOAD_PAD, CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      LAST_NEVER, LAST_ALWAYS, LAST_PLAIN_MID, LAST_MID
   } last_type;

   typedef struct packed {
      emit_type   emit;
      cnt_op_type cnt_op;
      last_type   last;
      jump_type   jump;
      cond_type   cond;
      step_type   target;
   } ucode_type;

   // ---- inter-module bundles ----
   typedef struct packed {
      logic [4:0]  row_width;
      logic [4:0]  group_size;
      logic        uppercase;
      logic        plain_mode;
      logic [31:0] start_offset;
      logic        start_load;
      logic [31:0] length_limit;
      logic        limit_enabled;
   } cfg_type;

   typedef struct packed {
      logic slot_free;
      logic skip;
      logic first_normal;
      logic gap;
      logic row_end;
      logic plain;
      logic cnt_nz;
      logic side_more;
   } status_type;

   typedef struct packed {
      logic      go;
      logic      take;
      ucode_type word;
   } ctrl_type;

   // ---- step program ----
   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      unique case (s)
         STEP_WAIT:    w = '{EMIT_NONE,    CNT_LOAD_ADDR, LAST_NEVER,     JMP_START,
                             COND_ALWAYS,  STEP_WAIT};
         STEP_ADDR:    w = '{EMIT_ADDR,    CNT_DEC,       LAST_NEVER,     JMP_COND,
                             COND_CNT_NZ,  STEP_ADDR};
         STEP_COLON:   w = '{EMIT_COLON,   CNT_HOLD,      LAST_NEVER,     JMP_NEXT,
                             COND_ALWAYS,  STEP_WAIT};
         STEP_SEP:     w = '{EMIT_SPACE,   CNT_HOLD,      LAST_NEVER,     JMP_COND,
                             COND_ALWAYS,  STEP_HEX_HI};
         STEP_GAP:     w = '{EMIT_SPACE,   CNT_HOLD,      LAST_NEVER,     JMP_NEXT,
                             COND_ALWAYS,  STEP_WAIT};
         STEP_HEX_HI:  w = '{EMIT_HEX_HI,  CNT_HOLD,      LAST_NEVER,     JMP_NEXT,
                             COND_ALWAYS,  STEP_WAIT};
         STEP_HEX_LO:  w = '{EMIT_HEX_LO,  CNT_HOLD,      LAST_PLAIN_MID, JMP_TAIL,
                             COND_ALWAYS,  STEP_WAIT};
         STEP_TRAIL:   w = '{EMIT_SPACE,   CNT_LOAD_PAD,  LAST_MID,       JMP_COND,
                             COND_MID_ROW, STEP_WAIT};
         STEP_PAD:     w = '{EMIT_SPACE,   CNT_DEC,       LAST_NEVER,     JMP_COND,
                             COND_CNT_NZ,  STEP_PAD};
         STEP_SIDE:    w = '{EMIT_SIDE,    CNT_HOLD,      LAST_NEVER,     JMP_COND,
                             COND_SIDE_MORE, STEP_SIDE};
         STEP_NEWLINE: w = '{EMIT_NEWLINE, CNT_HOLD,      LAST_ALWAYS,    JMP_COND,
                             COND_ALWAYS,  STEP_WAIT};
         default:      w = '{EMIT_NONE,    CNT_HOLD,      LAST_NEVER,     JMP_COND,
                             COND_ALWAYS,  STEP_WAIT};
      endcase
      return w;
   endfunction

   // ---- character helpers ----
   function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
      logic [7:0] base;
      if (nib < 4'd10) begin
         base = CH_ZERO;
      end else begin
         base = upper ? CH_UPPER_A_M10 : CH_LOWER_A_M10;
      end
      return base + {4'h0, nib};
   endfunction

   function automatic logic [7:0] side_char(logic [7:0] c);
      return (c >= CH_SPACE && c <= CH_TILDE) ? c : CH_DOT;
   endfunction

   // col is a whole number of groups of gs bytes; col stays within one row
   function automatic logic is_multiple(logic [4:0] col, logic [4:0] gs);
      logic       found;
      logic [9:0] prod;
      found = 1'b0;
      for (int k = 1; k <= COLS_LIMIT; k++) begin
         prod = 10'(gs) * 10'(k);
         if (prod == 10'(col)) begin
            found = 1'b1;
         end
      end
      return found;
   endfunction

endpackage

// File: hw/rtl/hdf_csr.sv
// ============================================================================
// hdf_csr - configuration registers
// APB-style register file; a write to the start offset also strobes the
// address counter load.
// ============================================================================
module hdf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hdf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output hdf_pkg::cfg_type                  cfg
);

   logic [4:0]  row_width_ff,  row_width_in;
   logic [4:0]  group_size_ff, group_size_in;
   logic        uppercase_ff,  uppercase_in;
   logic        plain_ff,      plain_in;
   logic [31:0] start_ff,      start_in;
   logic [31:0] limit_ff,      limit_in;
   logic        limit_en_ff,   limit_en_in;
   logic        wr;
   logic [2:0]  index;

   assign wr    = csr_psel & csr_penable & csr_pwrite;
   assign index = csr_paddr[4:2];

   always_comb begin
      row_width_in  = row_width_ff;
      group_size_in = group_size_ff;
      uppercase_in  = uppercase_ff;
      plain_in      = plain_ff;
      start_in      = start_ff;
      limit_in      = limit_ff;
      limit_en_in   = limit_en_ff;
      if (wr) begin
         unique case (index)
            hdf_pkg::REG_ROW_WIDTH:     row_width_in  = csr_pwdata[4:0];
            hdf_pkg::REG_GROUP_SIZE:    group_size_in = csr_pwdata[4:0];
            hdf_pkg::REG_UPPERCASE:     uppercase_in  = csr_pwdata[0];
            hdf_pkg::REG_PLAIN_MODE:    plain_in      = csr_pwdata[0];
            hdf_pkg::REG_START_OFFSET:  start_in      = csr_pwdata;
            hdf_pkg::REG_LENGTH_LIMIT:  limit_in      = csr_pwdata;
            hdf_pkg::REG_LIMIT_ENABLED: limit_en_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= hdf_pkg::ROW_WIDTH_RESET;
         group_size_ff <= hdf_pkg::GROUP_SIZE_RESET;
         uppercase_ff  <= 1'b0;
         plain_ff      <= 1'b0;
         start_ff      <= '0;
         limit_ff      <= '0;
         limit_en_ff   <= 1'b0;
      end else begin
         row_width_ff  <= row_width_in;
         group_size_ff <= group_size_in;
         uppercase_ff  <= uppercase_in;
         plain_ff      <= plain_in;
         start_ff      <= start_in;
         limit_ff      <= limit_in;
         limit_en_ff   <= limit_en_in;
      end
   end

   always_comb begin
      unique case (index)
         hdf_pkg::REG_ROW_WIDTH:     csr_prdata = {27'd0, row_width_ff};
         hdf_pkg::REG_GROUP_SIZE:    csr_prdata = {27'd0, group_size_ff};
         hdf_pkg::REG_UPPERCASE:     csr_prdata = {31'd0, uppercase_ff};
         hdf_pkg::REG_PLAIN_MODE:    csr_prdata = {31'd0, plain_ff};
         hdf_pkg::REG_START_OFFSET:  csr_prdata = start_ff;
         hdf_pkg::REG_LENGTH_LIMIT:  csr_prdata = limit_ff;
         hdf_pkg::REG_LIMIT_ENABLED: csr_prdata = {31'd0, limit_en_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   assign cfg.row_width     = row_width_ff;
   assign cfg.group_size    = group_size_ff;
   assign cfg.uppercase     = uppercase_ff;
   assign cfg.plain_mode    = plain_ff;
   assign cfg.start_offset  = csr_pwdata;
   assign cfg.start_load    = wr && (index == hdf_pkg::REG_START_OFFSET);
   assign cfg.length_limit  = limit_ff;
   assign cfg.limit_enabled = limit_en_ff;

endmodule

// File: hw/rtl/hdf_seq.sv
// ============================================================================
// hdf_seq - microcode sequencer
// Step counter over the control store, with conditional jumps, a start
// dispatch per request and a tail dispatch after the hex digits.
// ============================================================================
module hdf_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hdf_pkg::status_type  status,
   output hdf_pkg::ctrl_type    ctrl
);

   hdf_pkg::step_type  step_ff, step_in;
   hdf_pkg::step_type  step_inc;
   hdf_pkg::step_type  next_step;
   hdf_pkg::ucode_type word;
   logic               is_wait;
   logic               take;
   logic               go;
   logic               cond_true;

   assign word     = hdf_pkg::ucode_rom(step_ff);
   assign is_wait  = (step_ff == hdf_pkg::STEP_WAIT);
   assign take     = is_wait & req_valid;
   assign go       = is_wait ? take : status.slot_free;
   assign step_inc = step_ff + 4'd1;

   always_comb begin
      unique case (word.cond)
         hdf_pkg::COND_ALWAYS:    cond_true = 1'b1;
         hdf_pkg::COND_CNT_NZ:    cond_true = status.cnt_nz;
         hdf_pkg::COND_SIDE_MORE: cond_true = status.side_more;
         hdf_pkg::COND_MID_ROW:   cond_true = !status.row_end;
         default:                 cond_true = 1'b1;
      endcase
   end

   always_comb begin
      next_step = step_inc;
      unique case (word.jump)
         hdf_pkg::JMP_NEXT: next_step = step_inc;
         hdf_pkg::JMP_COND: next_step = cond_true ? word.target : step_inc;
         hdf_pkg::JMP_START: begin
            priority if (status.skip)         next_step = hdf_pkg::STEP_WAIT;
            else if (status.first_normal)     next_step = hdf_pkg::STEP_ADDR;
            else if (status.gap)              next_step = hdf_pkg::STEP_GAP;
            else                              next_step = hdf_pkg::STEP_HEX_HI;
         end
         hdf_pkg::JMP_TAIL: begin
            priority if (!status.plain)       next_step = step_inc;
            else if (status.row_end)          next_step = hdf_pkg::STEP_NEWLINE;
            else                              next_step = hdf_pkg::STEP_WAIT;
         end
         default: next_step = hdf_pkg::STEP_WAIT;
      endcase
      step_in = go ? next_step : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= hdf_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign req_ready = is_wait;
   assign ctrl.go   = go;
   assign ctrl.take = take;
   assign ctrl.word = word;

endmodule

// File: hw/rtl/hdf_datapath.sv
// ============================================================================
// hdf_datapath - dump state, character selection and result register
// Holds the open row, column, address and byte counters, the loop counters
// the program steps through, and the output register.
// ============================================================================
module hdf_datapath #(
   parameter int MAX_COLS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  hdf_pkg::cfg_type    cfg,
   input  hdf_pkg::ctrl_type   ctrl,
   output hdf_pkg::status_type status,
   input  logic [7:0]          req_data_byte,
   input  logic                req_final_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_run_last
);

   localparam int COL_W = $clog2(MAX_COLS + 1);
   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_W = $clog2(3 * MAX_COLS + hdf_pkg::ADDR_DIGITS);

   logic [COL_W-1:0] col_ff,      col_in;
   logic [31:0]      addr_ff,     addr_in;
   logic [31:0]      done_ff,     done_in;
   logic             fin_ff,      fin_in;
   logic [7:0]       byte_ff,     byte_in;
   logic             row_end_ff,  row_end_in;
   logic [CNT_W-1:0] pad3_ff,     pad3_in;
   logic [IDX_W-1:0] side_end_ff, side_end_in;
   logic [IDX_W-1:0] side_idx_ff, side_idx_in;
   logic [31:0]      addr_sh_ff,  addr_sh_in;
   logic [CNT_W-1:0] cnt_ff,      cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff,  rsp_char_in;
   logic             rsp_last_ff,  rsp_last_in;
   logic [7:0]       row_ff [MAX_COLS];

   logic [4:0]       cols_sat;
   logic [COL_W-1:0] cols;
   logic [IDX_W-1:0] idx;
   logic [COL_W-1:0] new_col;
   logic [COL_W-1:0] pad_cols;
   logic [CNT_W-1:0] pad3;
   logic [31:0]      done_nx;
   logic             passed;
   logic             limit_hit;
   logic             row_end_nx;
   logic             skip;
   logic             take_ok;
   logic [7:0]       char_sel;
   logic             last_sel;

   // ---- decisions for an arriving request ----
   always_comb begin
      if (cfg.row_width == 5'd0) begin
         cols_sat = 5'd1;
      end else if (cfg.row_width > 5'(MAX_COLS)) begin
         cols_sat = 5'(MAX_COLS);
      end else begin
         cols_sat = cfg.row_width;
      end
   end

   assign cols      = COL_W'(cols_sat);
   assign idx       = (col_ff < COL_W'(MAX_COLS)) ? IDX_W'(col_ff) : IDX_W'(MAX_COLS - 1);
   assign new_col   = COL_W'(idx) + COL_W'(1);
   assign pad_cols  = (new_col < cols) ? (cols - new_col) : '0;
   assign pad3      = (CNT_W'(pad_cols) << 1) + CNT_W'(pad_cols);
   assign done_nx   = done_ff + 32'd1;
   assign passed    = cfg.limit_enabled && (done_ff >= cfg.length_limit);
   assign limit_hit = cfg.limit_enabled && (done_nx >= cfg.length_limit);
   assign row_end_nx = (new_col >= cols) || req_final_byte || limit_hit;
   assign skip      = fin_ff || passed;
   assign take_ok   = ctrl.take && !skip;

   assign status.slot_free    = !rsp_valid_ff || rsp_ready;
   assign status.skip         = skip;
   assign status.first_normal = !cfg.plain_mode && (col_ff == '0);
   assign status.gap          = cfg.plain_mode && (col_ff != '0) && (cfg.group_size != 5'd0)
                                && hdf_pkg::is_multiple(5'(col_ff), cfg.group_size);
   assign status.row_end      = row_end_ff;
   assign status.plain        = cfg.plain_mode;
   assign status.cnt_nz       = (cnt_ff != '0);
   assign status.side_more    = (side_idx_ff != side_end_ff);

   // ---- character selection ----
   always_comb begin
      unique case (ctrl.word.emit)
         hdf_pkg::EMIT_NONE:    char_sel = '0;
         hdf_pkg::EMIT_ADDR:    char_sel = hdf_pkg::hex_char(addr_sh_ff[31:28], cfg.uppercase);
         hdf_pkg::EMIT_COLON:   char_sel = hdf_pkg::CH_COLON;
         hdf_pkg::EMIT_SPACE:   char_sel = hdf_pkg::CH_SPACE;
         hdf_pkg::EMIT_HEX_HI:  char_sel = hdf_pkg::hex_char(byte_ff[7:4], cfg.uppercase);
         hdf_pkg::EMIT_HEX_LO:  char_sel = hdf_pkg::hex_char(byte_ff[3:0], cfg.uppercase);
         hdf_pkg::EMIT_SIDE:    char_sel = hdf_pkg::side_char(row_ff[side_idx_ff]);
         hdf_pkg::EMIT_NEWLINE: char_sel = hdf_pkg::CH_NEWLINE;
         default:               char_sel = '0;
      endcase
      unique case (ctrl.word.last)
         hdf_pkg::LAST_NEVER:     last_sel = 1'b0;
         hdf_pkg::LAST_ALWAYS:    last_sel = 1'b1;
         hdf_pkg::LAST_PLAIN_MID: last_sel = cfg.plain_mode && !row_end_ff;
         hdf_pkg::LAST_MID:       last_sel = !row_end_ff;
         default:                 last_sel = 1'b0;
      endcase
   end

   // ---- next state ----
   always_comb begin
      col_in       = col_ff;
      addr_in      = addr_ff;
      done_in      = done_ff;
      fin_in       = fin_ff;
      byte_in      = byte_ff;
      row_end_in   = row_end_ff;
      pad3_in      = pad3_ff;
      side_end_in  = side_end_ff;
      side_idx_in  = side_idx_ff;
      addr_sh_in   = addr_sh_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      if (take_ok) begin
         col_in      = row_end_nx ? '0 : new_col;
         done_in     = done_nx;
         byte_in     = req_data_byte;
         row_end_in  = row_end_nx;
         pad3_in     = pad3;
         side_end_in = idx;
         side_idx_in = '0;
         addr_sh_in  = addr_ff;
         if (row_end_nx) begin
            addr_in = addr_ff + 32'(new_col);
         end
         if (row_end_nx && (req_final_byte || limit_hit)) begin
            fin_in = 1'b1;
         end
      end
      if (cfg.start_load) begin
         addr_in = cfg.start_offset;
      end

      if (ctrl.go) begin
         unique case (ctrl.word.cnt_op)
            hdf_pkg::CNT_HOLD:      cnt_in = cnt_ff;
            hdf_pkg::CNT_LOAD_ADDR: cnt_in = CNT_W'(hdf_pkg::ADDR_DIGITS - 1);
            hdf_pkg::CNT_LOAD_PAD:  cnt_in = pad3_ff;
            hdf_pkg::CNT_DEC:       cnt_in = cnt_ff - CNT_W'(1);
            default:                cnt_in = cnt_ff;
         endcase
         if (ctrl.word.emit == hdf_pkg::EMIT_ADDR) begin
            addr_sh_in = addr_sh_ff << 4;
         end
         if (ctrl.word.emit == hdf_pkg::EMIT_SIDE) begin
            side_idx_in = side_idx_ff + IDX_W'(1);
         end
      end

      if (ctrl.go && (ctrl.word.emit != hdf_pkg::EMIT_NONE)) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = char_sel;
         rsp_last_in  = last_sel;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         addr_ff      <= '0;
         done_ff      <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         addr_ff      <= addr_in;
         done_ff      <= done_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      row_end_ff  <= row_end_in;
      pad3_ff     <= pad3_in;
      side_end_ff <= side_end_in;
      side_idx_ff <= side_idx_in;
      addr_sh_ff  <= addr_sh_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (take_ok) begin
         row_ff[idx] <= req_data_byte;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

// File: hw/rtl/hex_dump_formatter.sv
// ============================================================================
// hex_dump_formatter - byte stream to hex dump text, one character per result
// Top level: register file, microcode sequencer and datapath.
// ============================================================================
// Usage
//   req_*  : one raw byte per request (req_data_byte, req_final_byte).
//   rsp_*  : one ASCII character per result; rsp_run_last marks the last
//            character that a request causes.
//   csr_*  : APB-style register port, register i at byte address 4*i; write
//            only while the block is idle. A start offset write also loads
//            the running address.
// Operation
//   A request is taken in the wait step; the step that follows writes its
//   first character into the result register. The sequencer then leaves
//   one character per cycle unless the receiver stalls. A request gives
//   3 characters in normal mode, plus 10 on the first byte of a row, plus
//   3*pad + sidebar + 2 on the last; 2 in plain mode, plus 1 for a group
//   gap and 1 for the newline. A request after the end of the dump, or past
//   the length limit, is taken in the wait step and gives no result.
// Reset clears the sequencer, dump counters and pending result and restores the
// register defaults. When the receiver stalls, hold the result register and
// freeze the program; the next request is taken as soon as the last
// character of the previous one sits in the result register.
// ============================================================================
module hex_dump_formatter #(
   parameter int MAX_COLS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_final_byte,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_char,
   output logic                           rsp_run_last,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [hdf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   hdf_pkg::cfg_type    cfg;
   hdf_pkg::status_type status;
   hdf_pkg::ctrl_type   ctrl;

   // Registers; the start offset strobe reaches the address counter directly.
   hdf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Step counter and ROM; past wait, advance only when the result slot frees.
   hdf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Row store, counters and result register, driven by the control word.
   hdf_datapath #(
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .ctrl           (ctrl),
      .status         (status),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

// File: hw/rtl/hdf_checker.sv
// ============================================================================
// hdf_checker - port-level checks for the hex dump block
// Watches the request and result channels and flags sequencing slips.
// ============================================================================
module hdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_last
);

   // Drop any pending result on reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Hold a stalled result.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_run_last))
      else $error("stalled result changed");

   // Take no request while a request still has characters to come.
   a_no_take_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !req_ready)
      else $error("request taken before the previous run ended");

   // A newline always closes a run.
   a_newline_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_char == 8'h0a) |-> rsp_run_last)
      else $error("newline not marked as last of run");

   // Take a request only while no result is pending or the pending one ends its run.
   a_take_idle_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid |-> rsp_run_last)
      else $error("request taken while a run was open");

endmodule

bind hex_dump_formatter hdf_checker u_hdf_checker (.*);

// File: tb/sv/hex_dump_formatter_test.sv
// ============================================================================
// hex_dump_formatter_test - self-checking bench for the hex dump formatter
// Streams raw bytes through the request channel under changing row formats,
// address offsets, length limits and handshake pressure. Every dump character
// is predicted in the bench and checked in order against the result channel.
// ============================================================================
module hex_dump_formatter_test;

   localparam int ROW_MAX      = 16;
   localparam int RANDOM_ITEMS = 420;
   localparam int DRAIN_CYCLES = 16;      // an ignored request retires in the wait step
   localparam int LONG_HOLD    = 400;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [8*16-1:0] HEX_LOWER = "0123456789abcdef";
   localparam logic [8*16-1:0] HEX_UPPER = "0123456789ABCDEF";

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } byte_req_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } dump_char_type;

   // ---- ports ----
   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_data_byte  = 8'h00;
   logic                           req_final_byte = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready      = 1'b0;
   logic [7:0]                     rsp_out_char;
   logic                           rsp_run_last;
   logic                           csr_psel       = 1'b0;
   logic                           csr_penable    = 1'b0;
   logic                           csr_pwrite     = 1'b0;
   logic [hdf_pkg::CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [31:0]                    csr_pwdata     = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   // ---- bench state ----
   byte_req_type  pending_bytes[$];    // requests waiting for the driver
   dump_char_type expected_chars[$];   // predicted dump text, oldest first
   int         sender_idle_pct    = 0;
   int         receiver_stall_pct = 0;
   int         stall_requests     = 0; // raised by the stimulus, served by the monitor
   int         stalls_served      = 0;
   int         hold_left          = 0;
   int         mismatch_count     = 0;
   int         cycle_count        = 0;

   // format registers as last written
   logic [4:0]  fmt_row_width  = hdf_pkg::ROW_WIDTH_RESET;
   logic [4:0]  fmt_group_size = hdf_pkg::GROUP_SIZE_RESET;
   logic        fmt_upper      = 1'b0;
   logic        fmt_plain      = 1'b0;
   logic [31:0] fmt_limit      = 32'h0;
   logic        fmt_limit_on   = 1'b0;

   // dump progress
   logic [7:0]  open_row [ROW_MAX];
   int          row_fill     = 0;
   logic [31:0] line_address = 32'h0;
   logic [31:0] dumped_count = 32'h0;
   logic        dump_closed  = 1'b0;

   hex_dump_formatter #(.MAX_COLS(ROW_MAX)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #2 clock = ~clock;

   // ---- prediction ----
   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      return fmt_upper ? HEX_UPPER[8*(15-nib) +: 8] : HEX_LOWER[8*(15-nib) +: 8];
   endfunction

   // Work out the characters that one accepted byte produces and queue them.
   function automatic void predict_dump_text(input logic [7:0] data, input logic fin);
      logic [7:0] text[$];
      dump_char_type c;
      int         cols;
      int         slot;
      logic       limit_hit;
      // a closed dump, or a limit already reached, swallows the byte silently
      if (dump_closed) return;
      if (fmt_limit_on && dumped_count >= fmt_limit) return;
      cols = fmt_row_width;
      if (cols < 1) cols = 1;
      if (cols > ROW_MAX) cols = ROW_MAX;

      if (!fmt_plain) begin
         // address only on the first byte of a row
         if (row_fill == 0) begin
            for (int k = 7; k >= 0; k--) text.push_back(hex_digit(line_address[4*k +: 4]));
            text.push_back(":");
            text.push_back(" ");
         end
      end else if (row_fill > 0 && fmt_group_size != 0 && row_fill % fmt_group_size == 0) begin
         text.push_back(" ");
      end
      text.push_back(hex_digit(data[7:4]));
      text.push_back(hex_digit(data[3:0]));
      if (!fmt_plain) text.push_back(" ");

      slot = (row_fill < ROW_MAX) ? row_fill : ROW_MAX - 1;
      open_row[slot] = data;
      row_fill = slot + 1;
      dumped_count = dumped_count + 32'd1;
      limit_hit = fmt_limit_on && dumped_count >= fmt_limit;

      // close the row: pad short rows, then the sidebar, then the newline
      if (row_fill >= cols || fin || limit_hit) begin
         if (!fmt_plain) begin
            for (int i = row_fill; i < cols; i++) repeat (3) text.push_back(" ");
            text.push_back(" ");
            for (int i = 0; i < row_fill; i++) begin
               text.push_back((open_row[i] >= 8'h20 && open_row[i] <= 8'h7e) ? open_row[i] : ".");
            end
         end
         text.push_back("\n");
         line_address = line_address + 32'(row_fill);
         row_fill = 0;
         if (fin || limit_hit) dump_closed = 1'b1;
      end

      foreach (text[i]) begin
         c.ch = text[i];
         c.last = (i == text.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   // ---- request driver ----
   // Predict on acceptance, then offer the next queued byte unless idling.
   always @(posedge clock) begin : request_driver
      byte_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_dump_text(req_data_byte, req_final_byte);
         // hold valid and payload until the request is taken
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_req = pending_bytes.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= next_req.data;
               req_final_byte <= next_req.fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---- result monitor ----
   // Check each accepted character against the oldest prediction, then pick the
   // next ready level: a long hold-off when one is asked for, else random stalls.
   always @(posedge clock) begin : result_monitor
      dump_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected character, expected none, got %h last %b",
                        $time, rsp_out_char, rsp_run_last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch || rsp_run_last !== want.last) begin
                  mismatch_count++;
                  if (rsp_out_char !== want.ch)
                     $display("%0t: out_char expected %h, got %h",
                              $time, want.ch, rsp_out_char);
                  if (rsp_run_last !== want.last)
                     $display("%0t: run_last expected %b, got %b",
                              $time, want.last, rsp_run_last);
               end
            end
         end
         if (stall_requests != stalls_served) begin
            stalls_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // ---- watchdog ----
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---- register access ----
   task automatic csr_read_check(input logic [2:0] index, input logic [31:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want) begin
         mismatch_count++;
         $display("%0t: register %0d read expected %h, got %h",
                  $time, index, want, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write a register, mirror it in the prediction state and read it back.
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] mask;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // the register takes the value at this edge
      mask = 32'hffff_ffff;
      unique case (index)
         hdf_pkg::REG_ROW_WIDTH: begin
            mask = 32'h1f;
            fmt_row_width = value[4:0];
         end
         hdf_pkg::REG_GROUP_SIZE: begin
            mask = 32'h1f;
            fmt_group_size = value[4:0];
         end
         hdf_pkg::REG_UPPERCASE: begin
            mask = 32'h1;
            fmt_upper = value[0];
         end
         hdf_pkg::REG_PLAIN_MODE: begin
            mask = 32'h1;
            fmt_plain = value[0];
         end
         hdf_pkg::REG_START_OFFSET: begin
            line_address = value;   // the running address reloads too
         end
         hdf_pkg::REG_LENGTH_LIMIT: begin
            fmt_limit = value;
         end
         hdf_pkg::REG_LIMIT_ENABLED: begin
            mask = 32'h1;
            fmt_limit_on = value[0];
         end
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_read_check(index, value & mask);
   endtask

   // ---- stimulus helpers ----
   function automatic void queue_byte(input logic [7:0] data, input logic fin);
      byte_req_type r;
      r.data = data;
      r.fin  = fin;
      pending_bytes.push_back(r);
   endfunction

   // Pause the sender until every predicted character has been seen, then
   // allow for requests that retire without output.
   task automatic wait_for_drain();
      while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---- test sequence ----
   initial begin : stimulus
      int          random_sent;
      int          phase;
      int          phase_items;
      int          finish_len;
      logic [79:0] boundary_bytes;
      logic [47:0] wrap_bytes;

      boundary_bytes = 80'h00_ff_1f_20_7e_7f_80_ab_cd_ef;
      wrap_bytes     = 48'hde_ad_be_ef_ca_fe;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // registers come out of reset at their defaults
      csr_read_check(hdf_pkg::REG_ROW_WIDTH,     32'(hdf_pkg::ROW_WIDTH_RESET));
      csr_read_check(hdf_pkg::REG_GROUP_SIZE,    32'(hdf_pkg::GROUP_SIZE_RESET));
      csr_read_check(hdf_pkg::REG_UPPERCASE,     32'h0);
      csr_read_check(hdf_pkg::REG_PLAIN_MODE,    32'h0);
      csr_read_check(hdf_pkg::REG_START_OFFSET,  32'h0);
      csr_read_check(hdf_pkg::REG_LENGTH_LIMIT,  32'h0);
      csr_read_check(hdf_pkg::REG_LIMIT_ENABLED, 32'h0);

      // directed: byte extremes and the printable boundaries, row left open
      for (int i = 9; i >= 0; i--) queue_byte(boundary_bytes[8*i +: 8], 1'b0);
      wait_for_drain();

      // width zero saturates to one and closes the open row with no padding
      csr_write(hdf_pkg::REG_ROW_WIDTH, 32'd0);
      queue_byte(8'h5a, 1'b0);
      queue_byte(8'ha5, 1'b0);
      wait_for_drain();

      // uppercase digits and an address that wraps past the top
      csr_write(hdf_pkg::REG_UPPERCASE, 32'd1);
      csr_write(hdf_pkg::REG_ROW_WIDTH, 32'd5);
      csr_write(hdf_pkg::REG_START_OFFSET, 32'hffff_fffe);
      for (int i = 5; i >= 0; i--) queue_byte(wrap_bytes[8*i +: 8], 1'b0);
      wait_for_drain();

      // plain mode with groups of three and an oversized width, then back to
      // normal mode in the middle of the row
      csr_write(hdf_pkg::REG_PLAIN_MODE, 32'd1);
      csr_write(hdf_pkg::REG_GROUP_SIZE, 32'd3);
      csr_write(hdf_pkg::REG_ROW_WIDTH, 32'd31);
      repeat (4) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_for_drain();
      csr_write(hdf_pkg::REG_PLAIN_MODE, 32'd0);
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_for_drain();

      // a zero limit already passed: bytes are dropped and the row stays open
      csr_write(hdf_pkg::REG_LENGTH_LIMIT, 32'd0);
      csr_write(hdf_pkg::REG_LIMIT_ENABLED, 32'd1);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h42, 1'b0);
      wait_for_drain();

      // random phases, each with its own format and idling profile
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
            default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
         endcase

         case ($urandom_range(0, 4))
            0: csr_write(hdf_pkg::REG_ROW_WIDTH, 32'd0);
            1: csr_write(hdf_pkg::REG_ROW_WIDTH, 32'd1);
            2: csr_write(hdf_pkg::REG_ROW_WIDTH, 32'd16);
            3: csr_write(hdf_pkg::REG_ROW_WIDTH, $urandom_range(17, 31));
            default: csr_write(hdf_pkg::REG_ROW_WIDTH, $urandom_range(2, 15));
         endcase
         case ($urandom_range(0, 4))
            0: csr_write(hdf_pkg::REG_GROUP_SIZE, 32'd0);
            1: csr_write(hdf_pkg::REG_GROUP_SIZE, 32'd1);
            2: csr_write(hdf_pkg::REG_GROUP_SIZE, 32'd16);
            3: csr_write(hdf_pkg::REG_GROUP_SIZE, $urandom_range(17, 31));
            default: csr_write(hdf_pkg::REG_GROUP_SIZE, $urandom_range(2, 8));
         endcase
         csr_write(hdf_pkg::REG_UPPERCASE, $urandom_range(0, 1));
         csr_write(hdf_pkg::REG_PLAIN_MODE, 32'($urandom_range(0, 2) == 0));
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1) == 0)
               csr_write(hdf_pkg::REG_START_OFFSET, $urandom());
            else
               csr_write(hdf_pkg::REG_START_OFFSET, 32'hffff_ffff - $urandom_range(0, 40));
         end

         // limit: now and then one already passed, now and then one far off
         case (phase % 6)
            3: begin
               case ($urandom_range(0, 2))
                  0: csr_write(hdf_pkg::REG_LENGTH_LIMIT, 32'd0);
                  1: csr_write(hdf_pkg::REG_LENGTH_LIMIT, dumped_count);
                  default: csr_write(hdf_pkg::REG_LENGTH_LIMIT,
                                     $urandom_range(0, dumped_count));
               endcase
               csr_write(hdf_pkg::REG_LIMIT_ENABLED, 32'd1);
            end
            5: begin
               if ($urandom_range(0, 1) == 0)
                  csr_write(hdf_pkg::REG_LENGTH_LIMIT, 32'hffff_ffff);
               else
                  csr_write(hdf_pkg::REG_LENGTH_LIMIT, dumped_count + 32'd100000);
               csr_write(hdf_pkg::REG_LIMIT_ENABLED, 32'd1);
            end
            default: csr_write(hdf_pkg::REG_LIMIT_ENABLED, 32'd0);
         endcase

         // first phase: hold the receiver off while the sender keeps going
         if (phase == 0) stall_requests++;
         phase_items = (phase == 0) ? 60 : $urandom_range(20, 60);
         repeat (phase_items) queue_byte(8'($urandom_range(0, 255)), 1'b0);
         random_sent += phase_items;
         wait_for_drain();
         phase++;
      end

      // close the dump either on the final byte or by reaching the limit
      sender_idle_pct    = 32;
      receiver_stall_pct = 32;
      finish_len = $urandom_range(1, 20);
      if ($urandom_range(0, 1) == 0) begin
         csr_write(hdf_pkg::REG_LIMIT_ENABLED, 32'd0);
         repeat (finish_len - 1) queue_byte(8'($urandom_range(0, 255)), 1'b0);
         queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         csr_write(hdf_pkg::REG_LENGTH_LIMIT, dumped_count + 32'(finish_len));
         csr_write(hdf_pkg::REG_LIMIT_ENABLED, 32'd1);
         repeat (finish_len) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      // anything after the end of the dump must stay silent
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
      queue_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
